// File: hw/rtl/rle_pkg.sv
package rle_pkg;

  localparam int ID_BITS   = 16;
  localparam int MAX_PHASE = 16;
  localparam int KIND_W    = 2;
  localparam int PHASE_W   = 6;
  localparam int HOPS_W    = 18;
  localparam int SPAN_W    = 34;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_MSG   = 1'b1;

  localparam logic [KIND_W-1:0] KIND_PROBE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPLY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LEADER = 2'd2;

  localparam logic signed [HOPS_W-1:0]  HOPS_MAX   = {1'b0, {(HOPS_W-1){1'b1}}};
  localparam logic signed [HOPS_W-1:0]  HOPS_NONE  = '1;
  localparam logic signed [HOPS_W-1:0]  HOPS_ONE   = HOPS_W'(1);
  localparam logic signed [PHASE_W-1:0] PHASE_NONE = '1;
  localparam logic signed [PHASE_W-1:0] PHASE_ZERO = '0;
  localparam logic signed [PHASE_W-1:0] PHASE_MAX  = PHASE_W'(MAX_PHASE);

  typedef struct packed {
    logic                      action;
    logic [KIND_W-1:0]         msg_kind;
    logic [ID_BITS-1:0]        msg_id;
    logic signed [PHASE_W-1:0] msg_phase;
    logic signed [HOPS_W-1:0]  msg_hops;
    logic                      from_right;
  } item_t;

  typedef struct packed {
    logic                      has_message;
    logic                      to_right;
    logic [KIND_W-1:0]         out_kind;
    logic [ID_BITS-1:0]        out_id;
    logic signed [PHASE_W-1:0] out_phase;
    logic signed [HOPS_W-1:0]  out_hops;
    logic                      finished;
    logic [ID_BITS-1:0]        elected_id;
    logic                      last;
  } result_t;

  typedef struct packed {
    logic [ID_BITS-1:0]        max_seen;
    logic                      candidate_valid;
    logic [ID_BITS-1:0]        candidate_id;
    logic                      candidate_from_right;
    logic signed [PHASE_W-1:0] led_phase;
    logic                      reply_count;
    logic                      halted;
  } state_t;

endpackage

// File: hw/rtl/rle_msg_if.sv
interface rle_msg_if;
  logic                                        valid;
  logic                                        ready;
  logic                                        action;
  logic [rle_pkg::KIND_W-1:0]                  msg_kind;
  logic [rle_pkg::ID_BITS-1:0]                 msg_id;
  logic signed [rle_pkg::PHASE_W-1:0]          msg_phase;
  logic signed [rle_pkg::HOPS_W-1:0]           msg_hops;
  logic                                        from_right;

  modport source (output valid, action, msg_kind, msg_id, msg_phase, msg_hops, from_right,
                  input ready);
  modport sink (input valid, action, msg_kind, msg_id, msg_phase, msg_hops, from_right,
                output ready);
endinterface

// File: hw/rtl/rle_res_if.sv
interface rle_res_if;
  logic                               valid;
  logic                               ready;
  logic                               has_message;
  logic                               to_right;
  logic [rle_pkg::KIND_W-1:0]         out_kind;
  logic [rle_pkg::ID_BITS-1:0]        out_id;
  logic signed [rle_pkg::PHASE_W-1:0] out_phase;
  logic signed [rle_pkg::HOPS_W-1:0]  out_hops;
  logic                               finished;
  logic [rle_pkg::ID_BITS-1:0]        elected_id;
  logic                               last;

  modport source (output valid, has_message, to_right, out_kind, out_id, out_phase,
                  out_hops, finished, elected_id, last, input ready);
  modport sink (input valid, has_message, to_right, out_kind, out_id, out_phase,
                out_hops, finished, elected_id, last, output ready);
endinterface

// File: hw/rtl/rle_cfg_if.sv
interface rle_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rle_pkg::ID_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hw/rtl/ring_leader_election_node.sv
// An accepted message waits in a pending register; its results then enter the queue.
// Throughput: one transaction per cycle when each yields at most one result
//   and results are taken; two-result transactions are limited by the result port.
// Results queue in a four-entry buffer; input stalls when more than two are waiting.
// Reset (synchronous, active high): clears election state, own_id and the result queue.
module ring_leader_election_node (
  input logic       clk,
  input logic       rst,
  rle_msg_if.sink   msg,
  rle_res_if.source res,
  rle_cfg_if.sink   cfg
);

  localparam int RES_DEPTH = 4;
  localparam int PTR_W     = 2;
  localparam int CNT_W     = 3;

  logic [rle_pkg::ID_BITS-1:0] own_id;
  rle_pkg::state_t             st;
  rle_pkg::state_t             st_next;
  logic                        pend_valid;
  rle_pkg::item_t              pend;
  rle_pkg::result_t            fifo [RES_DEPTH];
  logic [PTR_W-1:0]            wptr;
  logic [PTR_W-1:0]            rptr;
  logic [CNT_W-1:0]            count;
  logic [1:0]                  n_res;
  rle_pkg::result_t            res0;
  rle_pkg::result_t            res1;
  logic                        fire;
  logic                        pop;
  logic                        take;
  rle_pkg::item_t              msg_item;

  assign msg_item.action     = msg.action;
  assign msg_item.msg_kind   = msg.msg_kind;
  assign msg_item.msg_id     = msg.msg_id;
  assign msg_item.msg_phase  = msg.msg_phase;
  assign msg_item.msg_hops   = msg.msg_hops;
  assign msg_item.from_right = msg.from_right;

  rle_step u_step (
    .item    (pend),
    .st      (st),
    .own_id  (own_id),
    .st_next (st_next),
    .n_res   (n_res),
    .res0    (res0),
    .res1    (res1)
  );

  assign fire      = pend_valid && (count <= CNT_W'(2));
  assign msg.ready = !pend_valid || fire;
  assign take      = msg.valid && msg.ready;
  assign res.valid = (count != '0);
  assign pop       = res.valid && res.ready;
  assign cfg.ready = 1'b1;

  assign res.has_message = fifo[rptr].has_message;
  assign res.to_right    = fifo[rptr].to_right;
  assign res.out_kind    = fifo[rptr].out_kind;
  assign res.out_id      = fifo[rptr].out_id;
  assign res.out_phase   = fifo[rptr].out_phase;
  assign res.out_hops    = fifo[rptr].out_hops;
  assign res.finished    = fifo[rptr].finished;
  assign res.elected_id  = fifo[rptr].elected_id;
  assign res.last        = fifo[rptr].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id                  <= '0;
      st.max_seen             <= '0;
      st.candidate_valid      <= 1'b0;
      st.candidate_id         <= '0;
      st.candidate_from_right <= 1'b0;
      st.led_phase            <= rle_pkg::PHASE_NONE;
      st.reply_count          <= 1'b0;
      st.halted               <= 1'b0;
      pend_valid              <= 1'b0;
      wptr                    <= '0;
      rptr                    <= '0;
      count                   <= '0;
    end else begin
      if (cfg.valid) begin
        own_id <= cfg.data;
      end
      if (fire) begin
        st <= st_next;
      end
      if (take) begin
        pend_valid <= 1'b1;
      end else if (fire) begin
        pend_valid <= 1'b0;
      end
      if (fire) begin
        wptr <= wptr + PTR_W'(n_res);
      end
      if (pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      count <= count + CNT_W'(fire ? n_res : 2'd0) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend <= msg_item;
    end
    if (fire && n_res != 2'd0) begin
      fifo[wptr] <= res0;
    end
    if (fire && n_res == 2'd2) begin
      fifo[wptr + PTR_W'(1)] <= res1;
    end
  end

endmodule

// File: hw/rtl/rle_step.sv
module rle_step (
  input  rle_pkg::item_t             item,
  input  rle_pkg::state_t            st,
  input  logic [rle_pkg::ID_BITS-1:0] own_id,
  output rle_pkg::state_t            st_next,
  output logic [1:0]                 n_res,
  output rle_pkg::result_t           res0,
  output rle_pkg::result_t           res1
);

  function automatic rle_pkg::result_t mk(
    input logic                               right,
    input logic [rle_pkg::KIND_W-1:0]         kind,
    input logic [rle_pkg::ID_BITS-1:0]        id,
    input logic signed [rle_pkg::PHASE_W-1:0] phase,
    input logic signed [rle_pkg::HOPS_W-1:0]  hops,
    input logic                               fin
  );
    rle_pkg::result_t r;
    r.has_message = 1'b1;
    r.to_right    = right;
    r.out_kind    = kind;
    r.out_id      = id;
    r.out_phase   = phase;
    r.out_hops    = hops;
    r.finished    = fin;
    r.elected_id  = fin ? id : '0;
    r.last        = 1'b0;
    return r;
  endfunction

  logic signed [rle_pkg::SPAN_W-1:0]  span;
  logic signed [rle_pkg::SPAN_W-1:0]  led_span;
  logic signed [rle_pkg::SPAN_W-1:0]  hops_x;
  logic signed [rle_pkg::HOPS_W-1:0]  hops_inc;
  logic signed [rle_pkg::PHASE_W-1:0] phase_inc;
  logic signed [rle_pkg::PHASE_W-1:0] led_inc;
  logic                               fr;
  logic [rle_pkg::ID_BITS-1:0]        id;

  assign fr = item.from_right;
  assign id = item.msg_id;

  assign span = item.msg_phase[rle_pkg::PHASE_W-1] ? '0 :
                (rle_pkg::SPAN_W'(1) << item.msg_phase[rle_pkg::PHASE_W-2:0]);
  assign led_span = st.led_phase[rle_pkg::PHASE_W-1] ? '0 :
                    (rle_pkg::SPAN_W'(1) << st.led_phase[rle_pkg::PHASE_W-2:0]);
  assign hops_x = {{(rle_pkg::SPAN_W-rle_pkg::HOPS_W){item.msg_hops[rle_pkg::HOPS_W-1]}},
                   item.msg_hops};
  assign hops_inc  = (item.msg_hops >= rle_pkg::HOPS_MAX) ? rle_pkg::HOPS_MAX :
                     item.msg_hops + rle_pkg::HOPS_ONE;
  assign phase_inc = (item.msg_phase >= rle_pkg::PHASE_MAX) ? rle_pkg::PHASE_MAX :
                     item.msg_phase + rle_pkg::PHASE_W'(1);
  assign led_inc   = (st.led_phase >= rle_pkg::PHASE_MAX) ? rle_pkg::PHASE_MAX :
                     st.led_phase + rle_pkg::PHASE_W'(1);

  always_comb begin
    st_next = st;
    n_res   = 2'd0;
    res0    = '0;
    res1    = '0;
    if (!st.halted) begin
      if (item.action == rle_pkg::ACT_START) begin
        st_next.max_seen = own_id;
        res0  = mk(1'b0, rle_pkg::KIND_PROBE, own_id, rle_pkg::PHASE_ZERO,
                   rle_pkg::HOPS_ONE, 1'b0);
        res1  = mk(1'b1, rle_pkg::KIND_PROBE, own_id, rle_pkg::PHASE_ZERO,
                   rle_pkg::HOPS_ONE, 1'b0);
        n_res = 2'd2;
      end else begin
        unique case (item.msg_kind)
          rle_pkg::KIND_PROBE: begin
            if (st.candidate_valid && fr != st.candidate_from_right &&
                st.candidate_id == id) begin
              st_next.halted = 1'b1;
              res0  = mk(1'b0, rle_pkg::KIND_LEADER, id, rle_pkg::PHASE_NONE,
                         rle_pkg::HOPS_NONE, 1'b1);
              res1  = mk(1'b1, rle_pkg::KIND_LEADER, id, rle_pkg::PHASE_NONE,
                         rle_pkg::HOPS_NONE, 1'b1);
              n_res = 2'd2;
            end else begin
              st_next.candidate_valid      = 1'b1;
              st_next.candidate_id         = id;
              st_next.candidate_from_right = fr;
              if (id == own_id) begin
                res0  = mk(1'b0, rle_pkg::KIND_LEADER, id, rle_pkg::PHASE_NONE,
                           rle_pkg::HOPS_NONE, 1'b0);
                n_res = 2'd1;
              end else if (id >= st.max_seen) begin
                st_next.max_seen = id;
                n_res = 2'd1;
                if (hops_x < span && !(st.led_phase != rle_pkg::PHASE_NONE &&
                                       (span - hops_x) <= led_span)) begin
                  res0 = mk(!fr, rle_pkg::KIND_PROBE, id, item.msg_phase, hops_inc, 1'b0);
                end else begin
                  res0 = mk(fr, rle_pkg::KIND_REPLY, id, item.msg_phase,
                            rle_pkg::HOPS_NONE, 1'b0);
                end
              end
            end
          end
          rle_pkg::KIND_REPLY: begin
            if (id >= st.max_seen) begin
              if (id != own_id) begin
                res0  = mk(!fr, rle_pkg::KIND_REPLY, id, item.msg_phase, item.msg_hops, 1'b0);
                n_res = 2'd1;
              end else if (!st.reply_count) begin
                st_next.reply_count = 1'b1;
              end else begin
                st_next.reply_count = 1'b0;
                st_next.led_phase   = led_inc;
                res0  = mk(1'b0, rle_pkg::KIND_PROBE, id, phase_inc, rle_pkg::HOPS_ONE, 1'b0);
                res1  = mk(1'b1, rle_pkg::KIND_PROBE, id, phase_inc, rle_pkg::HOPS_ONE, 1'b0);
                n_res = 2'd2;
              end
            end
          end
          rle_pkg::KIND_LEADER: begin
            st_next.halted = 1'b1;
            n_res = 2'd1;
            if (id != own_id) begin
              res0 = mk(!fr, rle_pkg::KIND_LEADER, id, item.msg_phase, item.msg_hops, 1'b1);
            end else begin
              res0.finished   = 1'b1;
              res0.elected_id = id;
            end
          end
          default: begin
          end
        endcase
      end
    end
    res0.last = (n_res == 2'd1);
    res1.last = 1'b1;
  end

endmodule
